// ===== rtl/lruc_pkg.sv =====
// Package for the LRU cache with idle-age expiry: opcodes, widths, defaults
// and the controller/datapath command and status structs. No dependencies.
`default_nettype none
package lruc_pkg;

    localparam int unsigned DEPTH_DEFAULT = 16;
    localparam int unsigned KEY_WIDTH_DEFAULT = 64;
    localparam int unsigned VALUE_WIDTH_DEFAULT = 64;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned CFG_W = 32;
    localparam int unsigned KEY_PORT_W = 64;
    localparam int unsigned VALUE_PORT_W = 64;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd60000;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_TICK   = 2'd2,
        OP_STOP   = 2'd3
    } op_t;

    typedef enum logic [0:0] {
        REG_TIMEOUT = 1'b0,
        REG_LIMIT   = 1'b1
    } reg_idx_t;

    // Scan: find and sweep walk positions 0..occupancy-1; trim drops position 0.
    typedef enum logic [1:0] {
        SCAN_FIND  = 2'd0,
        SCAN_SWEEP = 2'd1,
        SCAN_TRIM  = 2'd2
    } scan_kind_t;

    typedef struct packed {
        logic       scan_start;   // begin a walk of kind kind
        scan_kind_t kind;
        logic       hit_move;     // move the found entry to the most recent end
        logic       ins_remove;   // drop the found entry (if any) and the oldest when full
        logic       ins_write;    // write new entry at the most recent end
        logic       tick;         // advance time and timer
        logic       stop;         // clear and close
        logic       finish;       // emit result
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic sweep_due;
        logic over_limit;
        logic closed;
    } status_t;

endpackage
`default_nettype wire

// ===== rtl/lruc_ctrl.sv =====
// Controller state machine of the LRU cache: sequences lookup, insert, tick
// and stop over the datapath. Depends on lruc_pkg.
`default_nettype none
module lruc_ctrl
    import lruc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic [1:0] opcode,
    input  var  status_t sts,
    output var  cmd_t    cmd,
    output wire logic    busy
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_FIND   = 8'b0000_0010,
        S_HIT    = 8'b0000_0100,
        S_INSRM  = 8'b0000_1000,
        S_INSWR  = 8'b0001_0000,
        S_TRIM   = 8'b0010_0000,
        S_SWEEP  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   is_insert_reg, is_insert_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            is_insert_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            is_insert_reg <= is_insert_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        is_insert_next = is_insert_reg;
        cmd            = '0;
        cmd.kind       = SCAN_FIND;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (op_t'(opcode))
                        OP_LOOKUP, OP_INSERT:
                        begin
                            is_insert_next = (op_t'(opcode) == OP_INSERT);
                            if (sts.closed)
                                state_next = S_DONE;
                            else
                            begin
                                cmd.scan_start = 1'b1;
                                cmd.kind       = SCAN_FIND;
                                state_next     = S_FIND;
                            end
                        end
                        OP_TICK:
                        begin
                            cmd.tick   = 1'b1;
                            state_next = S_SWEEP;
                        end
                        OP_STOP:
                        begin
                            cmd.stop   = 1'b1;
                            state_next = S_DONE;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_FIND:
            begin
                if (sts.scan_done)
                begin
                    if (is_insert_reg)
                        state_next = S_INSRM;
                    else if (sts.found)
                        state_next = S_HIT;
                    else
                        state_next = S_DONE;
                end
            end
            S_HIT:
            begin
                cmd.hit_move = 1'b1;
                state_next   = S_DONE;
            end
            S_INSRM:
            begin
                cmd.ins_remove = 1'b1;
                state_next     = S_INSWR;
            end
            S_INSWR:
            begin
                cmd.ins_write = 1'b1;
                state_next    = S_TRIM;
            end
            S_TRIM:
            begin
                // Drop the oldest entry each cycle while above the limit.
                cmd.kind = SCAN_TRIM;
                if (sts.over_limit)
                    cmd.scan_start = 1'b1;
                else
                    state_next = S_DONE;
            end
            S_SWEEP:
            begin
                // The tick was applied on entry; start the sweep if it fell due.
                cmd.kind = SCAN_SWEEP;
                if (sts.sweep_due)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_FIND;
                    is_insert_next = 1'b0;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/lruc_dp.sv =====
// Datapath of the LRU cache: entry store, recency list, scan position,
// timers and result registers. Depends on lruc_pkg.
`default_nettype none
module lruc_dp
    import lruc_pkg::*;
#(
    parameter int unsigned DEPTH       = DEPTH_DEFAULT,
    parameter int unsigned KEY_WIDTH   = KEY_WIDTH_DEFAULT,
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic                    busy,
    input  wire logic [KEY_PORT_W-1:0]   key,
    input  wire logic [VALUE_PORT_W-1:0] value_in,
    input  wire logic                    cfg_we,
    input  wire logic                    cfg_idx,
    input  wire logic                    cfg_valid_idx,
    input  wire logic [CFG_W-1:0]        cfg_data,
    input  var  cmd_t                    cmd,
    output var  status_t                 sts,
    output wire logic                    hit,
    output wire logic [VALUE_PORT_W-1:0] value_out,
    output wire logic [COUNT_W-1:0]      entry_count,
    output wire logic                    closed,
    output wire logic                    result_valid
);

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned OCC_W = $clog2(DEPTH + 1);

    // Per-slot store; order_reg holds slot numbers, position 0 least recent.
    logic [KEY_WIDTH-1:0]   keys_reg   [DEPTH];
    logic [VALUE_WIDTH-1:0] vals_reg   [DEPTH];
    logic [TIME_W-1:0]      last_reg   [DEPTH];
    logic [IDX_W-1:0]       order_reg  [DEPTH];

    logic [OCC_W-1:0]       occ_reg;
    logic [TIME_W-1:0]      now_reg;
    logic [TIME_W-1:0]      countdown_reg;
    logic [TIME_W-1:0]      timeout_reg;
    logic [COUNT_W-1:0]     limit_reg;
    logic                   closed_reg;

    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] val_in_reg;

    logic                   scanning_reg;
    scan_kind_t             kind_reg;
    logic [OCC_W-1:0]       pos_reg;      // read position
    logic [OCC_W-1:0]       kept_reg;     // write position for sweep compaction
    logic                   found_reg;
    logic [IDX_W-1:0]       found_pos_reg;
    logic                   sweep_due_reg;

    logic                   hit_reg;
    logic [VALUE_WIDTH-1:0] vout_reg;
    logic                   rvalid_reg;

    logic [IDX_W-1:0]       cur_slot;
    logic                   scan_last;
    logic [TIME_W-1:0]      age;
    logic                   full_store;
    logic [OCC_W-1:0]       occ_after_rm;
    logic [DEPTH-1:0]       used;
    logic [IDX_W-1:0]       free_s;

    assign cur_slot  = order_reg[pos_reg[IDX_W-1:0]];
    assign scan_last = (pos_reg + OCC_W'(1) >= occ_reg);
    assign age       = now_reg - last_reg[cur_slot];

    // Occupancy after dropping a found entry, before making room.
    assign occ_after_rm = occ_reg - OCC_W'(found_reg);
    assign full_store   = (occ_after_rm >= OCC_W'(DEPTH));

    // Slot map of the live list; the free slot is the lowest unused.
    always_comb
    begin
        used = '0;
        for (int p = 0; p < DEPTH; p++)
        begin
            if (OCC_W'(p) < occ_reg)
                used[order_reg[p]] = 1'b1;
        end
        free_s = '0;
        for (int s = DEPTH - 1; s >= 0; s--)
        begin
            if (!used[s])
                free_s = IDX_W'(s);
        end
    end

    always_comb
    begin
        sts.scan_done  = scanning_reg ? 1'b0 : 1'b1;
        sts.found      = found_reg;
        sts.sweep_due  = sweep_due_reg;
        sts.over_limit = ({{(32-OCC_W){1'b0}}, occ_reg} > {27'd0, limit_reg});
        sts.closed     = closed_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            now_reg       <= '0;
            countdown_reg <= TIMEOUT_RESET;
            timeout_reg   <= TIMEOUT_RESET;
            limit_reg     <= LIMIT_RESET;
            closed_reg    <= 1'b0;
            scanning_reg  <= 1'b0;
            kind_reg      <= SCAN_FIND;
            pos_reg       <= '0;
            kept_reg      <= '0;
            found_reg     <= 1'b0;
            found_pos_reg <= '0;
            sweep_due_reg <= 1'b0;
            rvalid_reg    <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            rvalid_reg <= cmd.finish;
            if (cfg_we && cfg_valid_idx)
            begin
                if (reg_idx_t'(cfg_idx) == REG_TIMEOUT)
                    timeout_reg <= cfg_data;
                else
                    limit_reg <= cfg_data[COUNT_W-1:0];
            end
            if (start && !busy)
                hit_reg <= 1'b0;

            if (cmd.scan_start)
            begin
                unique case (cmd.kind)
                    SCAN_TRIM:
                    begin
                        // Drop position 0: shift the list down by one.
                        for (int q = 0; q < DEPTH - 1; q++)
                            order_reg[q] <= order_reg[q + 1];
                        occ_reg <= occ_reg - OCC_W'(1);
                    end
                    SCAN_SWEEP, SCAN_FIND:
                    begin
                        found_reg <= 1'b0;
                        pos_reg   <= '0;
                        kept_reg  <= '0;
                        kind_reg  <= cmd.kind;
                        if (occ_reg != '0)
                            scanning_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
            else if (scanning_reg)
            begin
                if (kind_reg == SCAN_FIND)
                begin
                    if (keys_reg[cur_slot] == key_reg)
                    begin
                        found_reg     <= 1'b1;
                        found_pos_reg <= pos_reg[IDX_W-1:0];
                        scanning_reg  <= 1'b0;
                    end
                    else if (scan_last)
                        scanning_reg <= 1'b0;
                    pos_reg <= pos_reg + OCC_W'(1);
                end
                else
                begin
                    if (age <= timeout_reg)
                    begin
                        order_reg[kept_reg[IDX_W-1:0]] <= cur_slot;
                        kept_reg <= kept_reg + OCC_W'(1);
                    end
                    if (scan_last)
                    begin
                        scanning_reg <= 1'b0;
                        occ_reg <= kept_reg + OCC_W'(age <= timeout_reg);
                    end
                    pos_reg <= pos_reg + OCC_W'(1);
                end
            end

            if (cmd.hit_move)
            begin
                // Rotate the found entry to the end of the list.
                for (int q = 0; q < DEPTH; q++)
                begin
                    if (IDX_W'(q) >= found_pos_reg && OCC_W'(q) + OCC_W'(1) < occ_reg)
                        order_reg[q] <= order_reg[q + 1 < DEPTH ? q + 1 : q];
                end
                order_reg[occ_reg[IDX_W-1:0] - IDX_W'(1)] <=
                    order_reg[found_pos_reg];
                hit_reg <= 1'b1;
            end

            if (cmd.ins_remove)
            begin
                // Close the gap at the found position, or drop the oldest when full.
                for (int q = 0; q < DEPTH - 1; q++)
                begin
                    if (full_store || (found_reg && IDX_W'(q) >= found_pos_reg))
                        order_reg[q] <= order_reg[q + 1];
                end
                occ_reg <= occ_after_rm - OCC_W'(full_store);
            end

            if (cmd.ins_write)
            begin
                order_reg[occ_reg[IDX_W-1:0]] <= free_s;
                occ_reg <= occ_reg + OCC_W'(1);
            end

            if (cmd.tick)
            begin
                now_reg       <= now_reg + TIME_W'(1);
                sweep_due_reg <= !closed_reg && (countdown_reg == TIME_W'(1));
                if (!closed_reg && countdown_reg != '0)
                begin
                    if (countdown_reg == TIME_W'(1))
                        countdown_reg <= timeout_reg;
                    else
                        countdown_reg <= countdown_reg - TIME_W'(1);
                end
            end

            if (cmd.stop)
            begin
                occ_reg       <= '0;
                countdown_reg <= '0;
                closed_reg    <= 1'b1;
            end
        end
    end

    // Payload: captured words, store contents and read data.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            key_reg    <= key[KEY_WIDTH-1:0];
            val_in_reg <= value_in[VALUE_WIDTH-1:0];
        end
        if (cmd.hit_move)
        begin
            last_reg[order_reg[found_pos_reg]] <= now_reg;
            vout_reg <= vals_reg[order_reg[found_pos_reg]];
        end
        if (cmd.ins_write)
        begin
            keys_reg[free_s] <= key_reg;
            vals_reg[free_s] <= val_in_reg;
            last_reg[free_s] <= now_reg;
        end
    end

    // During a lookup walk the position never passes occupancy.
    logic [VALUE_PORT_W-1:0] vout_ext;
    assign vout_ext = {{(VALUE_PORT_W-VALUE_WIDTH){1'b0}}, vout_reg};

    assign hit          = hit_reg;
    assign value_out    = hit_reg ? vout_ext : '0;
    assign entry_count  = COUNT_W'(occ_reg);
    assign closed       = closed_reg;
    assign result_valid = rvalid_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy above depth");
    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg && !cmd.scan_start |=> occ_reg == '0)
        else $error("closed store holds entries");
    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |=> closed_reg)
        else $error("closed flag dropped");
    a_hit_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hit_move |-> !closed_reg && found_reg)
        else $error("hit without a found entry");

endmodule
`default_nettype wire

// ===== rtl/lru_cache_with_age_eviction.sv =====
// Top level of the LRU cache with idle-age expiry: joins controller and
// datapath. Depends on lruc_pkg, lruc_ctrl and lruc_dp.
//
// Usage: raise start with opcode, key and value_in while busy is low; the
// word is taken at that edge and busy rises. Exactly one result word per
// command appears on hit, value_out, entry_count and closed, marked by
// done for one cycle; it cannot be held off, so capture it then.
// A lookup compares one stored entry a cycle; a tick also sweeps the store
// when the sweep timer expires; an insert trims one entry per cycle while
// above the size limit. One command at a time; busy is low during the done
// cycle, so the next word may be taken at the edge that ends it.
// Configuration: cfg_we, cfg_index, cfg_data write idle_timeout_ticks (0)
// or size_limit (1) at once; the user must write them only while idle, as
// the block does not enforce this. Reset clears the store, time and closed
// flag and reloads the timer.
`default_nettype none
module lru_cache_with_age_eviction
    import lruc_pkg::*;
#(
    parameter int unsigned DEPTH       = DEPTH_DEFAULT,
    parameter int unsigned KEY_WIDTH   = KEY_WIDTH_DEFAULT,
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output wire logic                    busy,
    input  wire logic [1:0]              opcode,
    input  wire logic [KEY_PORT_W-1:0]   key,
    input  wire logic [VALUE_PORT_W-1:0] value_in,
    output wire logic                    done,
    output wire logic                    hit,
    output wire logic [VALUE_PORT_W-1:0] value_out,
    output wire logic [COUNT_W-1:0]      entry_count,
    output wire logic                    closed,
    input  wire logic                    cfg_we,
    input  wire logic [0:0]              cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data
);

    cmd_t    cmd;
    status_t sts;

    lruc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    lruc_dp #(
        .DEPTH       (DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .key           (key),
        .value_in      (value_in),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_index[0]),
        .cfg_valid_idx (1'b1),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .sts           (sts),
        .hit           (hit),
        .value_out     (value_out),
        .entry_count   (entry_count),
        .closed        (closed),
        .result_valid  (done)
    );

endmodule
`default_nettype wire

// ===== test/lruc_checker.sv =====
// Checker for the LRU cache with idle-age expiry: watches the command, result
// and register ports, predicts each result word and compares. Depends on lruc_pkg.
module lruc_checker
    import lruc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [1:0]              opcode,
    input  logic [KEY_PORT_W-1:0]   key,
    input  logic [VALUE_PORT_W-1:0] value_in,
    input  logic                    done,
    input  logic                    hit,
    input  logic [VALUE_PORT_W-1:0] value_out,
    input  logic [COUNT_W-1:0]      entry_count,
    input  logic                    closed,
    input  logic                    cfg_we,
    input  logic [0:0]              cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    output int                      mismatches,
    output int                      outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 16;

    typedef struct {
        logic [63:0]       k;
        logic [63:0]       v;
        logic [TIME_W-1:0] last;
    } line_t;

    typedef struct packed {
        logic               hit;
        logic [63:0]        value;
        logic [COUNT_W-1:0] count;
        logic               closed;
    } word_t;

    // lines[0] is least recently used
    line_t             lines[$];
    logic [TIME_W-1:0] timeout_ticks;
    logic [COUNT_W-1:0] limit;
    logic [TIME_W-1:0] now_ticks;
    logic [TIME_W-1:0] countdown;
    logic              shut;
    word_t             pending_words[$];

    function automatic int locate(logic [63:0] k);
        foreach (lines[i])
            if (lines[i].k == k)
                return i;
        return -1;
    endfunction

    function automatic word_t apply_command(op_t op, logic [63:0] k, logic [63:0] v);
        word_t w;
        line_t ln;
        line_t kept[$];
        int    p;
        w = '0;
        case (op)
            OP_LOOKUP:
            begin
                p = shut ? -1 : locate(k);
                if (p >= 0)
                begin
                    ln = lines[p];
                    ln.last = now_ticks;
                    lines.delete(p);
                    lines.insert(lines.size(), ln);
                    w.hit = 1'b1;
                    w.value = ln.v;
                end
            end
            OP_INSERT:
            begin
                if (!shut)
                begin
                    p = locate(k);
                    if (p >= 0)
                        lines.delete(p);
                    if (lines.size() >= CAPACITY)
                        lines.delete(0);
                    ln.k = k;
                    ln.v = v;
                    ln.last = now_ticks;
                    lines.insert(lines.size(), ln);
                    while (lines.size() > limit && lines.size() > 0)
                        lines.delete(0);
                end
            end
            OP_TICK:
            begin
                now_ticks++;
                if (!shut && countdown != 0)
                begin
                    countdown--;
                    if (countdown == 0)
                    begin
                        // drop lines idle for longer than the timeout
                        foreach (lines[i])
                            if (TIME_W'(now_ticks - lines[i].last) <= timeout_ticks)
                                kept.insert(kept.size(), lines[i]);
                        lines = kept;
                        countdown = timeout_ticks;
                    end
                end
            end
            default:
            begin
                lines.delete();
                countdown = '0;
                shut = 1'b1;
            end
        endcase
        w.count = COUNT_W'(lines.size());
        w.closed = shut;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        word_t want;
        if (!rst_n)
        begin
            lines.delete();
            pending_words.delete();
            timeout_ticks = TIMEOUT_RESET;
            limit = LIMIT_RESET;
            now_ticks = '0;
            countdown = TIMEOUT_RESET;
            shut = 1'b0;
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_TIMEOUT)
                    timeout_ticks = cfg_data;
                else
                    limit = cfg_data[COUNT_W-1:0];
            end
            if (start && !busy)
                pending_words.insert(pending_words.size(),
                    apply_command(op_t'(opcode), key, value_in));
            if (done)
            begin
                if (pending_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word at %0t", $realtime);
                end
                else
                begin
                    want = pending_words[0];
                    pending_words.delete(0);
                    if (hit !== want.hit || value_out !== want.value
                        || entry_count !== want.count || closed !== want.closed)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display(
                                "%0t got/exp hit %0b/%0b val %h/%h cnt %0d/%0d closed %0b/%0b",
                                $realtime, hit, want.hit, value_out, want.value,
                                entry_count, want.count, closed, want.closed);
                    end
                end
            end
            outstanding = pending_words.size();
        end
    end
endmodule

// ===== test/tb_lru_cache_with_age_eviction.sv =====
// Testbench top for the LRU cache with idle-age expiry: drives commands and
// register writes, gives the verdict. Depends on lruc_pkg, lruc_checker and the block.
module tb_lru_cache_with_age_eviction
    import lruc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic [1:0]              opcode = OP_LOOKUP;
    logic [KEY_PORT_W-1:0]   key = '0;
    logic [VALUE_PORT_W-1:0] value_in = '0;
    logic                    cfg_we = 1'b0;
    logic [0:0]              cfg_index = REG_TIMEOUT;
    logic [CFG_W-1:0]        cfg_data = '0;
    wire logic               busy, done, hit, closed;
    wire logic [VALUE_PORT_W-1:0] value_out;
    wire logic [COUNT_W-1:0] entry_count;
    int                      mismatches, outstanding;
    int                      cycles = 0;
    int                      idle_pct = 0;
    logic [63:0]             key_pool[12];

    always #5 clk = ~clk;

    lru_cache_with_age_eviction dut (.*);

    lruc_checker u_checker (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // present one word and hold it until taken
    task automatic issue(op_t op, logic [63:0] k, logic [63:0] v);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        opcode = op;
        key = k;
        value_in = v;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_word();
        int          r;
        logic [63:0] k;
        r = $urandom_range(99);
        k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(11)] : rand64();
        if (r < 40)
            issue(OP_LOOKUP, k, rand64());
        else if (r < 80)
            issue(OP_INSERT, k, rand64());
        else
            issue(OP_TICK, rand64(), rand64());
    endtask

    initial
    begin
        logic [CFG_W-1:0] timeouts[8] = '{7, 3, 12, 7, 1, 32'hFFFF_FFFF, 20, 0};
        logic [4:0]       limits[8]   = '{16, 0, 1, 31, 5, 17, 16, 8};
        int               idles[4]    = '{0, 71, 0, 19};
        foreach (key_pool[i])
            key_pool[i] = rand64();
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, replace, miss, hit, tick, overflow
        issue(OP_LOOKUP, '0, '0);
        issue(OP_INSERT, '0, '1);
        issue(OP_INSERT, '1, '0);
        issue(OP_LOOKUP, '0, '0);
        issue(OP_LOOKUP, '1, '1);
        issue(OP_INSERT, '0, 64'h5555_AAAA_5555_AAAA);
        issue(OP_LOOKUP, '0, '0);
        issue(OP_LOOKUP, 64'h1234, '0);
        issue(OP_TICK, '0, '0);
        for (int i = 0; i < 17; i++)
            issue(OP_INSERT, 64'(i) + 64'hA000_0000_0000_0000, rand64());
        issue(OP_LOOKUP, 64'hA000_0000_0000_0000, '0);
        issue(OP_LOOKUP, 64'hA000_0000_0000_0010, '0);
        settle();

        foreach (timeouts[p])
        begin
            write_reg(REG_TIMEOUT, timeouts[p]);
            write_reg(REG_LIMIT, limits[p]);
            idle_pct = idles[p % 4];
            for (int i = 0; i < 220; i++)
                random_word();
            settle();
        end

        // stop, then the closed block
        write_reg(REG_TIMEOUT, 5);
        write_reg(REG_LIMIT, 16);
        idle_pct = 19;
        for (int i = 0; i < 20; i++)
            random_word();
        issue(OP_STOP, rand64(), rand64());
        for (int i = 0; i < 30; i++)
            random_word();
        issue(OP_STOP, '0, '0);
        issue(OP_LOOKUP, key_pool[2], '0);
        settle();

        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
